// File: rtl/sscr_pkg.sv
`default_nettype none
package sscr_pkg;

    // field widths
    localparam int SIZE_W  = 12;
    localparam int POS_W   = 16;
    localparam int SCALE_W = 10;
    localparam int SRC_W   = 24;
    localparam int SCR_W   = 12;

    // internal widths
    localparam int PROD_W  = 28;   // scale * offset, signed
    localparam int MAG_W   = PROD_W - 1;
    localparam int QD_W    = 20;   // |product| / 100
    localparam int EDGE_W  = 21;   // unclipped edge, signed
    localparam int NUM_W   = 26;   // 100 * clipped amount
    localparam int RP_W    = MAG_W + 28;

    // divide by 100: (x * RECIP100) >> RECIP_SHIFT, exact for x < 2**30
    localparam logic [27:0] RECIP100    = 28'd171798692;
    localparam int          RECIP_SHIFT = 34;

    localparam logic [NUM_W-1:0] HUNDRED = NUM_W'(100);

    // divider depth, one quotient bit per stage
    localparam int DIV_STAGES = NUM_W;

    // screen reset values
    localparam logic [SCR_W-1:0] SCREEN_W_RST = SCR_W'(640);
    localparam logic [SCR_W-1:0] SCREEN_H_RST = SCR_W'(480);

    // register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // per-item data carried alongside the dividers (index 0 = x, 1 = y)
    typedef struct packed {
        logic                       vis;
        logic [1:0]                 clip_lo;
        logic [1:0]                 clip_hi;
        logic [1:0][SCR_W-1:0]      dst_lo;
        logic [1:0][SCR_W-1:0]      dst_hi;
        logic [1:0][SIZE_W-1:0]     size;
    } side_t;

endpackage
`default_nettype wire

// File: rtl/scaled_sprite_clip_rect_core.sv
// Scaled sprite rectangle clipping core.
// Structure: 5 setup stages, 26-stage dividers for the source edge correction,
// one output register.
// Throughput: one sprite per cycle unless the output stalls; the divider pipelines set the depth.
// Reset: rst_n asynchronous active low, clears valid bits; screen size to 640x480.
`default_nettype none
module scaled_sprite_clip_rect_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [11:0] sprite_width,
    input  wire logic [11:0] sprite_height,
    input  wire logic signed [15:0] draw_x,
    input  wire logic signed [15:0] draw_y,
    input  wire logic signed [15:0] anchor_x,
    input  wire logic signed [15:0] anchor_y,
    input  wire logic [9:0]  scale_percent,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             visible,
    output logic signed [23:0] src_left,
    output logic signed [23:0] src_top,
    output logic signed [23:0] src_right,
    output logic signed [23:0] src_bottom,
    output logic [11:0]      dst_left,
    output logic [11:0]      dst_top,
    output logic [11:0]      dst_right,
    output logic [11:0]      dst_bottom
);

    localparam int SIZE_W  = sscr_pkg::SIZE_W;
    localparam int POS_W   = sscr_pkg::POS_W;
    localparam int SCALE_W = sscr_pkg::SCALE_W;
    localparam int PROD_W  = sscr_pkg::PROD_W;
    localparam int MAG_W   = sscr_pkg::MAG_W;
    localparam int QD_W    = sscr_pkg::QD_W;
    localparam int EDGE_W  = sscr_pkg::EDGE_W;
    localparam int NUM_W   = sscr_pkg::NUM_W;
    localparam int SCR_W   = sscr_pkg::SCR_W;
    localparam int SRC_W   = sscr_pkg::SRC_W;
    localparam int RP_W    = sscr_pkg::RP_W;
    localparam int DS      = sscr_pkg::DIV_STAGES;

    // configuration registers
    logic [SCR_W-1:0] screen_w_reg;
    logic [SCR_W-1:0] screen_h_reg;
    logic [1:0][SCR_W-1:0] screen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= sscr_pkg::SCREEN_W_RST;
            screen_h_reg <= sscr_pkg::SCREEN_H_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                sscr_pkg::REG_SCREEN_WIDTH:  screen_w_reg <= cfg_data;
                sscr_pkg::REG_SCREEN_HEIGHT: screen_h_reg <= cfg_data;
                default:                     screen_w_reg <= screen_w_reg;
            endcase
        end
    end

    assign screen[0] = screen_w_reg;
    assign screen[1] = screen_h_reg;

    // pipeline control: whole pipe moves when the output can move
    logic en;
    logic load0;
    logic out_valid_reg;
    logic [4:1] v_reg;
    logic v0_reg;
    logic [DS-1:0] sv_reg;

    assign en       = !out_valid_reg || out_ready;
    assign load0    = en || !v0_reg;
    assign in_ready = load0;

    // stage 0: input capture
    logic [1:0][SIZE_W-1:0]        s0_size_reg;
    logic [1:0][POS_W-1:0]         s0_pos_reg;
    logic [1:0][POS_W-1:0]         s0_anc_reg;
    logic [SCALE_W-1:0]            s0_sc_reg;

    always_ff @(posedge clk)
    begin
        if (load0 && in_valid)
        begin
            s0_size_reg[0] <= sprite_width;
            s0_size_reg[1] <= sprite_height;
            s0_pos_reg[0]  <= draw_x;
            s0_pos_reg[1]  <= draw_y;
            s0_anc_reg[0]  <= anchor_x;
            s0_anc_reg[1]  <= anchor_y;
            s0_sc_reg      <= scale_percent;
        end
    end

    // stage 1: scale times anchor and times far offset
    logic [1:0][PROD_W-1:0] s1_plo_next, s1_phi_next;
    logic [1:0][PROD_W-1:0] s1_plo_reg, s1_phi_reg;
    logic [1:0][SIZE_W-1:0] s1_size_reg;
    logic [1:0][POS_W-1:0]  s1_pos_reg;
    logic [SCALE_W-1:0]     s1_sc_reg;

    always_comb
    begin
        logic signed [17:0]       diff;
        logic signed [PROD_W:0]   plo;
        logic signed [PROD_W:0]   phi;
        for (int a = 0; a < 2; a++)
        begin
            diff = $signed({6'b0, s0_size_reg[a]})
                 - $signed({{2{s0_anc_reg[a][POS_W-1]}}, s0_anc_reg[a]});
            plo  = $signed({1'b0, s0_sc_reg}) * $signed(s0_anc_reg[a]);
            phi  = $signed({1'b0, s0_sc_reg}) * diff;
            s1_plo_next[a] = plo[PROD_W-1:0];
            s1_phi_next[a] = phi[PROD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_plo_reg  <= s1_plo_next;
            s1_phi_reg  <= s1_phi_next;
            s1_size_reg <= s0_size_reg;
            s1_pos_reg  <= s0_pos_reg;
            s1_sc_reg   <= s0_sc_reg;
        end
    end

    // stage 2: truncating divide by 100 via reciprocal multiply
    logic [1:0][QD_W-1:0] s2_qlo_next, s2_qhi_next, s2_qlo_reg, s2_qhi_reg;
    logic [1:0]           s2_slo_reg, s2_shi_reg;
    logic [1:0][SIZE_W-1:0] s2_size_reg;
    logic [1:0][POS_W-1:0]  s2_pos_reg;
    logic [SCALE_W-1:0]     s2_sc_reg;

    always_comb
    begin
        logic [PROD_W-1:0] neg;
        logic [MAG_W-1:0]  mag;
        logic [RP_W-1:0]   rp;
        for (int a = 0; a < 2; a++)
        begin
            neg = PROD_W'(0) - s1_plo_reg[a];
            mag = s1_plo_reg[a][PROD_W-1] ? neg[MAG_W-1:0] : s1_plo_reg[a][MAG_W-1:0];
            rp  = RP_W'(mag) * RP_W'(sscr_pkg::RECIP100);
            s2_qlo_next[a] = rp[sscr_pkg::RECIP_SHIFT +: QD_W];
            neg = PROD_W'(0) - s1_phi_reg[a];
            mag = s1_phi_reg[a][PROD_W-1] ? neg[MAG_W-1:0] : s1_phi_reg[a][MAG_W-1:0];
            rp  = RP_W'(mag) * RP_W'(sscr_pkg::RECIP100);
            s2_qhi_next[a] = rp[sscr_pkg::RECIP_SHIFT +: QD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_qlo_reg  <= s2_qlo_next;
            s2_qhi_reg  <= s2_qhi_next;
            s2_slo_reg  <= {s1_plo_reg[1][PROD_W-1], s1_plo_reg[0][PROD_W-1]};
            s2_shi_reg  <= {s1_phi_reg[1][PROD_W-1], s1_phi_reg[0][PROD_W-1]};
            s2_size_reg <= s1_size_reg;
            s2_pos_reg  <= s1_pos_reg;
            s2_sc_reg   <= s1_sc_reg;
        end
    end

    // stage 3: unclipped edges around the anchor
    logic [1:0][EDGE_W-1:0] s3_lo_next, s3_hi_next, s3_lo_reg, s3_hi_reg;
    logic [1:0][SIZE_W-1:0] s3_size_reg;
    logic [SCALE_W-1:0]     s3_sc_reg;

    always_comb
    begin
        logic [EDGE_W-1:0] pe;
        logic [EDGE_W-1:0] ql;
        logic [EDGE_W-1:0] qh;
        for (int a = 0; a < 2; a++)
        begin
            pe = {{(EDGE_W-POS_W){s2_pos_reg[a][POS_W-1]}}, s2_pos_reg[a]};
            ql = {1'b0, s2_qlo_reg[a]};
            qh = {1'b0, s2_qhi_reg[a]};
            // subtract the signed quotient: sign chooses add or subtract
            s3_lo_next[a] = s2_slo_reg[a] ? pe + ql : pe - ql;
            s3_hi_next[a] = s2_shi_reg[a] ? pe - qh : pe + qh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_lo_reg   <= s3_lo_next;
            s3_hi_reg   <= s3_hi_next;
            s3_size_reg <= s2_size_reg;
            s3_sc_reg   <= s2_sc_reg;
        end
    end

    // stage 4: visibility, clip flags, divider numerators
    sscr_pkg::side_t        s4_side_next, s4_side_reg;
    logic [1:0][NUM_W-1:0]  s4_nlo_next, s4_nhi_next, s4_nlo_reg, s4_nhi_reg;
    logic [SCALE_W-1:0]     s4_sc_reg;

    always_comb
    begin
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] hi;
        logic signed [EDGE_W-1:0] scr;
        logic [EDGE_W-1:0]        amt_lo;
        logic [EDGE_W-1:0]        amt_hi;
        logic [1:0]               vis_a;
        for (int a = 0; a < 2; a++)
        begin
            lo  = $signed(s3_lo_reg[a]);
            hi  = $signed(s3_hi_reg[a]);
            scr = $signed({{(EDGE_W-SCR_W){1'b0}}, screen[a]});
            vis_a[a] = (lo < scr) && (hi > $signed(EDGE_W'(0)));
            s4_side_next.clip_lo[a] = lo < $signed(EDGE_W'(0));
            s4_side_next.clip_hi[a] = hi > scr;
            amt_lo = EDGE_W'(0) - s3_lo_reg[a];
            amt_hi = s3_hi_reg[a] - EDGE_W'(scr);
            s4_nlo_next[a] = s4_side_next.clip_lo[a] ? NUM_W'(amt_lo) * sscr_pkg::HUNDRED : '0;
            s4_nhi_next[a] = s4_side_next.clip_hi[a] ? NUM_W'(amt_hi) * sscr_pkg::HUNDRED : '0;
            s4_side_next.dst_lo[a] = s4_side_next.clip_lo[a] ? '0 : s3_lo_reg[a][SCR_W-1:0];
            s4_side_next.dst_hi[a] = s4_side_next.clip_hi[a] ? screen[a]
                                                              : s3_hi_reg[a][SCR_W-1:0];
            s4_side_next.size[a] = s3_size_reg[a];
        end
        s4_side_next.vis = vis_a[0] && vis_a[1] && (s3_sc_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            s4_nlo_reg  <= s4_nlo_next;
            s4_nhi_reg  <= s4_nhi_next;
            s4_sc_reg   <= s3_sc_reg;
        end
    end

    // source edge corrections: 100 * amount / scale
    logic [1:0][NUM_W-1:0] qlo, qhi;

    for (genvar a = 0; a < 2; a++)
    begin : g_div
        sscr_div u_div_lo
        (
            .clk (clk),
            .en  (en),
            .num (s4_nlo_reg[a]),
            .den (s4_sc_reg),
            .quo (qlo[a])
        );
        sscr_div u_div_hi
        (
            .clk (clk),
            .en  (en),
            .num (s4_nhi_reg[a]),
            .den (s4_sc_reg),
            .quo (qhi[a])
        );
    end

    // side data shift line matching the divider depth
    sscr_pkg::side_t side_reg [DS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s4_side_reg;
            for (int k = 1; k < DS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v_reg         <= '0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load0)
            begin
                v0_reg <= in_valid;
            end
            if (en)
            begin
                v_reg         <= {v_reg[3:1], v0_reg};
                sv_reg        <= {sv_reg[DS-2:0], v_reg[4]};
                out_valid_reg <= sv_reg[DS-1];
            end
        end
    end

    // output stage: apply corrections, zero everything when invisible
    sscr_pkg::side_t       fs;
    logic [1:0][SRC_W-1:0] src_lo_next, src_hi_next, src_lo_reg, src_hi_reg;
    logic [1:0][SCR_W-1:0] dlo_next, dhi_next, dlo_reg, dhi_reg;
    logic                  vis_reg;

    assign fs = side_reg[DS-1];

    always_comb
    begin
        logic [NUM_W:0] shi;
        for (int a = 0; a < 2; a++)
        begin
            shi = {{(NUM_W+1-SIZE_W){1'b0}}, fs.size[a]}
                - (fs.clip_hi[a] ? {1'b0, qhi[a]} : '0);
            src_lo_next[a] = (fs.vis && fs.clip_lo[a]) ? qlo[a][SRC_W-1:0] : '0;
            src_hi_next[a] = fs.vis ? shi[SRC_W-1:0] : '0;
            dlo_next[a]    = fs.vis ? fs.dst_lo[a] : '0;
            dhi_next[a]    = fs.vis ? fs.dst_hi[a] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg    <= fs.vis;
            src_lo_reg <= src_lo_next;
            src_hi_reg <= src_hi_next;
            dlo_reg    <= dlo_next;
            dhi_reg    <= dhi_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign visible    = vis_reg;
    assign src_left   = src_lo_reg[0];
    assign src_top    = src_lo_reg[1];
    assign src_right  = src_hi_reg[0];
    assign src_bottom = src_hi_reg[1];
    assign dst_left   = dlo_reg[0];
    assign dst_top    = dlo_reg[1];
    assign dst_right  = dhi_reg[0];
    assign dst_bottom = dhi_reg[1];

`ifndef SYNTHESIS
    // a free output slot always frees the input
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output side ready");

    // clipped destination is never inverted
    a_dst_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (dst_left <= dst_right && dst_top <= dst_bottom))
        else $error("inverted destination rectangle");

    // invisible sprites carry an all-zero rectangle
    a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (src_left == 24'sd0 && src_top == 24'sd0 &&
            src_right == 24'sd0 && src_bottom == 24'sd0 && dst_left == 12'd0 &&
            dst_top == 12'd0 && dst_right == 12'd0 && dst_bottom == 12'd0))
        else $error("invisible beat with nonzero rectangle");
`endif

endmodule
`default_nettype wire

// File: rtl/sscr_div.sv
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module sscr_div
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [sscr_pkg::NUM_W-1:0]          num,
    input  wire logic [sscr_pkg::SCALE_W-1:0]        den,
    output logic      [sscr_pkg::NUM_W-1:0]          quo
);

    localparam int N = sscr_pkg::DIV_STAGES;

    logic [sscr_pkg::NUM_W-1:0]   num_reg  [N];
    logic [sscr_pkg::SCALE_W-1:0] rem_reg  [N];
    logic [sscr_pkg::SCALE_W-1:0] den_reg  [N];
    logic [sscr_pkg::NUM_W-1:0]   num_next [N];
    logic [sscr_pkg::SCALE_W-1:0] rem_next [N];
    logic [sscr_pkg::SCALE_W-1:0] den_next [N];

    // each stage shifts in one numerator bit and trial-subtracts
    always_comb
    begin
        logic [sscr_pkg::NUM_W-1:0]   n;
        logic [sscr_pkg::SCALE_W-1:0] r;
        logic [sscr_pkg::SCALE_W-1:0] d;
        logic [sscr_pkg::SCALE_W:0]   t;
        logic                         ge;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                n = num;
                r = '0;
                d = den;
            end
            else
            begin
                n = num_reg[k-1];
                r = rem_reg[k-1];
                d = den_reg[k-1];
            end
            t  = {r, n[sscr_pkg::NUM_W-1]};
            ge = (t >= {1'b0, d});
            rem_next[k] = ge ? sscr_pkg::SCALE_W'(t - {1'b0, d})
                             : t[sscr_pkg::SCALE_W-1:0];
            num_next[k] = {n[sscr_pkg::NUM_W-2:0], ge};
            den_next[k] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = num_reg[N-1];

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int LATENCY     = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic               vis;
        logic signed [23:0] sl, st, sr, sb;
        logic [11:0]        dl, dt, dr, db;
    } clip_rect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = sscr_pkg::REG_SCREEN_WIDTH;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] sprite_width = '0, sprite_height = '0;
    logic signed [15:0] draw_x = '0, draw_y = '0, anchor_x = '0, anchor_y = '0;
    logic [9:0]  scale_percent = 10'd100;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        visible;
    logic signed [23:0] src_left, src_top, src_right, src_bottom;
    logic [11:0] dst_left, dst_top, dst_right, dst_bottom;

    // model copy of the screen registers
    longint scr_w = 640, scr_h = 480;
    clip_rect_t  rect_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          hold_sink = 1'b0;

    scaled_sprite_clip_rect_core dut (.*);

    always #4 clk = ~clk;

    // clip one axis; returns 0 when that axis is off screen
    function automatic bit clip_axis(longint pos, longint anc, longint size, longint sc,
                                     longint scr, output longint slo, output longint shi,
                                     output longint dlo, output longint dhi);
        longint lo, hi;
        lo = pos - (sc * anc) / 100;
        hi = pos + (sc * (size - anc)) / 100;
        slo = 0;
        shi = size;
        dlo = 0;
        dhi = 0;
        if (lo >= scr || hi <= 0)
            return 0;
        if (lo < 0)
        begin
            slo = slo + (-100 * lo) / sc;
            lo = 0;
        end
        if (hi > scr)
        begin
            shi = shi + (100 * (scr - hi)) / sc;
            hi = scr;
        end
        dlo = lo;
        dhi = hi;
        return 1;
    endfunction

    function automatic clip_rect_t predict_rect(logic [11:0] w, logic [11:0] h,
                                                logic signed [15:0] dx, logic signed [15:0] dy,
                                                logic signed [15:0] ax, logic signed [15:0] ay,
                                                logic [9:0] sc);
        clip_rect_t r;
        longint sl, sr, st, sb, dl, dr, dt, db;
        bit vx, vy;
        r = '{default: '0};
        if (sc == 0)
            return r;
        vx = clip_axis(longint'(dx), longint'(ax), longint'(w), longint'(sc), scr_w,
                       sl, sr, dl, dr);
        vy = clip_axis(longint'(dy), longint'(ay), longint'(h), longint'(sc), scr_h,
                       st, sb, dt, db);
        if (!(vx && vy))
            return r;
        r.vis = 1'b1;
        r.sl = sl[23:0];
        r.st = st[23:0];
        r.sr = sr[23:0];
        r.sb = sb[23:0];
        r.dl = dl[11:0];
        r.dt = dt[11:0];
        r.dr = dr[11:0];
        r.db = db[11:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // one register write; the write port is idle again when the task returns
    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == sscr_pkg::REG_SCREEN_WIDTH)
            scr_w = longint'(val);
        else
            scr_h = longint'(val);
        @(posedge clk);
    endtask

    // wait until every queued result has come, then drain the pipe
    task automatic drain;
        while (rect_q.size() != 0)
            @(posedge clk);
        wait_cycles(LATENCY + 4);
    endtask

    // one beat on the input side, with an optional idle gap in front
    task automatic send_sprite(logic [11:0] w, logic [11:0] h,
                               logic signed [15:0] dx, logic signed [15:0] dy,
                               logic signed [15:0] ax, logic signed [15:0] ay,
                               logic [9:0] sc, bit gaps);
        int g;
        if (gaps)
        begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if (g != 0)
            begin
                in_valid <= 1'b0;
                wait_cycles(g);
            end
        end
        in_valid      <= 1'b1;
        sprite_width  <= w;
        sprite_height <= h;
        draw_x        <= dx;
        draw_y        <= dy;
        anchor_x      <= ax;
        anchor_y      <= ay;
        scale_percent <= sc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rect_q.push_back(predict_rect(w, h, dx, dy, ax, ay, sc));
    endtask

    task automatic stop_sending;
        in_valid <= 1'b0;
    endtask

    // random sprite, mostly near the screen so clipping paths get hit
    task automatic send_random(bit gaps);
        logic [11:0] w, h;
        logic signed [15:0] dx, dy, ax, ay;
        logic [9:0] sc;
        if ($urandom_range(0, 4) == 0)
        begin
            {w, h} = 24'($urandom);
            {dx, dy} = $urandom;
            {ax, ay} = $urandom;
            sc = 10'($urandom);
        end
        else
        begin
            w  = 12'($urandom_range(0, 600));
            h  = 12'($urandom_range(0, 600));
            dx = 16'(int'($urandom_range(0, 1800)) - 600);
            dy = 16'(int'($urandom_range(0, 1800)) - 600);
            ax = 16'(int'($urandom_range(0, 800)) - 100);
            ay = 16'(int'($urandom_range(0, 800)) - 100);
            sc = ($urandom_range(0, 3) == 0) ? 10'd100 : 10'($urandom_range(1, 1023));
        end
        send_sprite(w, h, dx, dy, ax, ay, sc, gaps);
    endtask

    // result checker
    always @(posedge clk)
    begin
        clip_rect_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (rect_q.size() == 0)
            begin
                report("unexpected beat", longint'(visible), 0);
            end
            else
            begin
                e = rect_q.pop_front();
                if (visible !== e.vis)
                    report("visible", longint'(visible), longint'(e.vis));
                if (src_left !== e.sl)
                    report("src_left", longint'(src_left), longint'(e.sl));
                if (src_top !== e.st)
                    report("src_top", longint'(src_top), longint'(e.st));
                if (src_right !== e.sr)
                    report("src_right", longint'(src_right), longint'(e.sr));
                if (src_bottom !== e.sb)
                    report("src_bottom", longint'(src_bottom), longint'(e.sb));
                if (dst_left !== e.dl)
                    report("dst_left", longint'(dst_left), longint'(e.dl));
                if (dst_top !== e.dt)
                    report("dst_top", longint'(dst_top), longint'(e.dt));
                if (dst_right !== e.dr)
                    report("dst_right", longint'(dst_right), longint'(e.dr));
                if (dst_bottom !== e.db)
                    report("dst_bottom", longint'(dst_bottom), longint'(e.db));
            end
        end
    end

    // output side stalls: random, or held off for a long stretch
    always @(posedge clk)
    begin
        if (hold_sink)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_ready <= 1'b0;
        else if (!out_ready && $urandom_range(0, 3) != 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed;
        send_sprite(12'd100, 12'd100, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd0, 12'd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd4095, 12'd4095, 16'sd320, 16'sd240, 16'sd2047, 16'sd2047, 10'd1023, 0);
        send_sprite(12'd4095, 12'd4095, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767,
                    10'd1, 0);
        send_sprite(12'd4095, 12'd4095, 16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000,
                    10'd1023, 0);
        send_sprite(12'd50, 12'd50, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 10'd0, 0);
        send_sprite(12'd100, 12'd100, -16'sd50, -16'sd30, 16'sd0, 16'sd0, 10'd37, 0);
        send_sprite(12'd100, 12'd100, 16'sd600, 16'sd450, 16'sd0, 16'sd0, 10'd333, 0);
        send_sprite(12'd100, 12'd100, 16'sd640, 16'sd100, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd100, 12'd100, -16'sd100, 16'sd100, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd100, 12'd100, 16'sd100, 16'sd480, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd100, 12'd100, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 10'd100, 0);
        send_sprite(12'd200, 12'd200, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 10'd512, 0);
        send_sprite(12'd4095, 12'd1, -16'sd1, 16'sd479, -16'sd5, 16'sd0, 10'd999, 0);
        stop_sending();
        drain();
    endtask

    task automatic test_screen_sizes;
        logic [11:0] ws[4] = '{12'd1, 12'd4095, 12'd0, 12'd100};
        logic [11:0] hs[4] = '{12'd4095, 12'd1, 12'd0, 12'd77};
        foreach (ws[i])
        begin
            write_reg(sscr_pkg::REG_SCREEN_WIDTH, ws[i]);
            write_reg(sscr_pkg::REG_SCREEN_HEIGHT, hs[i]);
            send_sprite(12'd10, 12'd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd100, 0);
            repeat (150)
                send_random(1);
            stop_sending();
            drain();
        end
        write_reg(sscr_pkg::REG_SCREEN_WIDTH, 12'd640);
        write_reg(sscr_pkg::REG_SCREEN_HEIGHT, 12'd480);
    endtask

    task automatic test_random;
        repeat (850)
            send_random($urandom_range(0, 2) != 0);
        repeat (100)
            send_random(0);
        stop_sending();
        drain();
    endtask

    // sink stalls long enough for the pipe to back up into the input
    task automatic test_backpressure;
        fork
            begin
                hold_sink = 1'b1;
                wait_cycles(300);
                hold_sink = 1'b0;
            end
            repeat (100)
                send_random(0);
        join
        stop_sending();
        drain();
    endtask

    initial
    begin
        wait_cycles(5);
        rst_n <= 1'b1;
        wait_cycles(2);
        test_directed();
        test_screen_sizes();
        test_backpressure();
        test_random();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
